/* design/tppe_pkg.sv */
package tppe_pkg;

  localparam int SAMP_W             = 16;
  localparam int METRIC_W           = 16;
  localparam int LEN_W              = 7;
  localparam int OFF_W              = 6;
  localparam int IQ_W               = 2 * SAMP_W;
  localparam int MAX_PACKET_LEN_DEF = 64;
  localparam int CMDQ_DEPTH         = 4;
  localparam int CMDQ_AW            = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_LEN       = 2'd1;

  localparam logic [METRIC_W-1:0] THRESHOLD_RST  = 16'd32768;
  localparam logic [LEN_W-1:0]    PACKET_LEN_RST = 7'd64;

  typedef struct packed {
    logic signed [SAMP_W-1:0] sample_i;
    logic signed [SAMP_W-1:0] sample_q;
    logic [METRIC_W-1:0]      energy_metric;
    logic [METRIC_W-1:0]      sync_metric;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] out_i;
    logic signed [SAMP_W-1:0] out_q;
    logic                     last_in_packet;
    logic [OFF_W-1:0]         peak_offset;
  } out_item_t;

  typedef struct packed {
    logic [METRIC_W-1:0] energy_threshold;
    logic [LEN_W-1:0]    packet_len;
  } cfg_t;

  // one read burst for the back end: count samples from a ring start address
  typedef struct packed {
    logic [LEN_W-1:0] count;
    logic             last;
    logic [OFF_W-1:0] offset;
  } cmd_t;

  typedef struct packed {
    logic             last;
    logic [OFF_W-1:0] offset;
  } side_t;

endpackage

/* design/tppe_front.sv */
module tppe_front #(
  parameter int MAX_PACKET_LEN = tppe_pkg::MAX_PACKET_LEN_DEF,
  parameter int PTR_W          = $clog2(MAX_PACKET_LEN) + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tppe_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tppe_pkg::in_item_t   in_data,
  input  logic [PTR_W-1:0]     free_ptr,
  input  logic                 cmdq_full,
  output logic                 wr_en,
  output logic [PTR_W-1:0]     wr_ptr,
  output logic [tppe_pkg::IQ_W-1:0] wr_data,
  output logic                 cmd_push,
  output tppe_pkg::cmd_t       cmd,
  output logic [PTR_W-1:0]     cmd_start
);
  import tppe_pkg::*;

  localparam int RING_DEPTH = 1 << (PTR_W - 1);

  localparam logic [1:0] PH_SCAN    = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_PASS    = 2'd2;

  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PACKET_LEN);

  logic [1:0]          phase_r, phase_nxt;
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    base_r, base_nxt;
  logic [LEN_W-1:0]    win_cnt_r, win_cnt_nxt;
  logic [METRIC_W-1:0] best_sync_r, best_sync_nxt;
  logic [OFF_W-1:0]    best_off_r, best_off_nxt;
  logic [LEN_W-1:0]    emitted_r, emitted_nxt;

  logic [LEN_W-1:0] len_lo, len;
  logic             accept;
  logic             new_best;
  logic [OFF_W-1:0] cand_off;
  logic [LEN_W-1:0] cnt_inc;
  logic [LEN_W-1:0] win_emit;
  logic [LEN_W-1:0] pass_emit;
  logic [PTR_W-1:0] ring_occ;

  assign len_lo = (cfg.packet_len < LEN_MIN) ? LEN_MIN : cfg.packet_len;
  assign len    = (len_lo > LEN_MAX) ? LEN_MAX : len_lo;

  assign ring_occ = wr_ptr_r - free_ptr;
  assign in_ready = (ring_occ != PTR_W'(RING_DEPTH)) && !cmdq_full;
  assign accept   = in_valid && in_ready;

  assign new_best  = in_data.sync_metric > best_sync_r;
  assign cand_off  = new_best ? win_cnt_r[OFF_W-1:0] : best_off_r;
  assign cnt_inc   = win_cnt_r + LEN_W'(1);
  assign win_emit  = cnt_inc - LEN_W'(cand_off);
  assign pass_emit = emitted_r + LEN_W'(1);

  assign wr_ptr  = wr_ptr_r;
  assign wr_data = {in_data.sample_q, in_data.sample_i};

  always_comb begin
    phase_nxt     = phase_r;
    base_nxt      = base_r;
    win_cnt_nxt   = win_cnt_r;
    best_sync_nxt = best_sync_r;
    best_off_nxt  = best_off_r;
    emitted_nxt   = emitted_r;
    wr_en         = 1'b0;
    cmd_push      = 1'b0;
    cmd           = '0;
    cmd_start     = wr_ptr_r;
    case (phase_r)
      PH_COLLECT: begin
        if (accept) begin
          wr_en        = 1'b1;
          best_off_nxt = cand_off;
          win_cnt_nxt  = cnt_inc;
          if (new_best) begin
            best_sync_nxt = in_data.sync_metric;
          end
          if (cnt_inc >= len) begin
            cmd_push    = 1'b1;
            cmd.count   = win_emit;
            cmd.last    = win_emit >= len;
            cmd.offset  = cand_off;
            cmd_start   = base_r + PTR_W'(cand_off);
            emitted_nxt = win_emit;
            phase_nxt   = (win_emit >= len) ? PH_SCAN : PH_PASS;
          end
        end
      end
      PH_PASS: begin
        if (accept) begin
          wr_en       = 1'b1;
          cmd_push    = 1'b1;
          cmd.count   = LEN_W'(1);
          cmd.last    = pass_emit >= len;
          cmd.offset  = best_off_r;
          emitted_nxt = pass_emit;
          if (pass_emit >= len) begin
            phase_nxt = PH_SCAN;
          end
        end
      end
      default: begin
        phase_nxt = PH_SCAN;
        if (accept && (in_data.energy_metric > cfg.energy_threshold)) begin
          wr_en         = 1'b1;
          base_nxt      = wr_ptr_r;
          best_sync_nxt = in_data.sync_metric;
          best_off_nxt  = '0;
          win_cnt_nxt   = LEN_W'(1);
          emitted_nxt   = '0;
          phase_nxt     = PH_COLLECT;
        end
      end
    endcase
  end

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(wr_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SCAN;
      wr_ptr_r    <= '0;
      base_r      <= '0;
      win_cnt_r   <= '0;
      best_sync_r <= '0;
      best_off_r  <= '0;
      emitted_r   <= '0;
    end else begin
      phase_r     <= phase_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      base_r      <= base_nxt;
      win_cnt_r   <= win_cnt_nxt;
      best_sync_r <= best_sync_nxt;
      best_off_r  <= best_off_nxt;
      emitted_r   <= emitted_nxt;
    end
  end

endmodule

/* design/tppe_cmd_fifo.sv */
module tppe_cmd_fifo #(
  parameter int PTR_W = $clog2(tppe_pkg::MAX_PACKET_LEN_DEF) + 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tppe_pkg::cmd_t   push_cmd,
  input  logic [PTR_W-1:0] push_start,
  input  logic             pop,
  output tppe_pkg::cmd_t   head_cmd,
  output logic [PTR_W-1:0] head_start,
  output logic             head_valid,
  output logic             full
);
  import tppe_pkg::*;

  cmd_t             cmd_q     [CMDQ_DEPTH];
  logic [PTR_W-1:0] start_q   [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] head_r, head_nxt;
  logic [CMDQ_AW-1:0] tail_r, tail_nxt;
  logic [CMDQ_AW:0]   count_r, count_nxt;
  logic               do_pop;

  assign head_valid = count_r != '0;
  assign full       = count_r == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign do_pop     = pop && head_valid;
  assign head_cmd   = cmd_q[head_r];
  assign head_start = start_q[head_r];

  assign head_nxt  = head_r + CMDQ_AW'(do_pop);
  assign tail_nxt  = tail_r + CMDQ_AW'(push);
  assign count_nxt = count_r + (CMDQ_AW+1)'(push) - (CMDQ_AW+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[tail_r]   <= push_cmd;
      start_q[tail_r] <= push_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* design/tppe_back.sv */
module tppe_back #(
  parameter int MAX_PACKET_LEN = tppe_pkg::MAX_PACKET_LEN_DEF,
  parameter int PTR_W          = $clog2(MAX_PACKET_LEN) + 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [PTR_W-1:0]          wr_ptr,
  input  logic [tppe_pkg::IQ_W-1:0] wr_data,
  input  logic                      head_valid,
  input  tppe_pkg::cmd_t            head_cmd,
  input  logic [PTR_W-1:0]          head_start,
  output logic                      pop,
  output logic [PTR_W-1:0]          free_ptr,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tppe_pkg::out_item_t       out_data
);
  import tppe_pkg::*;

  localparam int RING_AW    = PTR_W - 1;
  localparam int RING_DEPTH = 1 << RING_AW;

  logic [IQ_W-1:0] ring_mem [RING_DEPTH];

  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] free_r, free_nxt;
  logic             rd_vld_r;
  side_t            rd_side_r;
  logic [IQ_W-1:0]  rd_data_r;

  out_item_t        obuf [2];
  logic             ohead_r, otail_r;
  logic [1:0]       occ_r, occ_nxt;

  logic             out_pop;
  logic             issue;
  logic             final_rd;
  logic [PTR_W-1:0] rd_addr;
  out_item_t        rd_item;

  assign out_valid = occ_r != 2'd0;
  assign out_data  = obuf[ohead_r];
  assign out_pop   = out_valid && out_ready;

  // credit check: buffered plus in-flight reads must fit the two-entry output buffer
  assign issue    = head_valid &&
                    (({1'b0, occ_r} + 3'(rd_vld_r)) < (3'd2 + 3'(out_pop)));
  assign final_rd = (cnt_r + LEN_W'(1)) == head_cmd.count;
  assign rd_addr  = head_start + PTR_W'(cnt_r);
  assign pop      = issue && final_rd;

  assign cnt_nxt  = issue ? (final_rd ? '0 : cnt_r + LEN_W'(1)) : cnt_r;
  assign free_nxt = issue ? rd_addr + PTR_W'(1) : free_r;
  assign free_ptr = free_r;

  assign occ_nxt = occ_r + 2'(rd_vld_r) - 2'(out_pop);

  always_comb begin
    rd_item.out_i          = rd_data_r[SAMP_W-1:0];
    rd_item.out_q          = rd_data_r[IQ_W-1:SAMP_W];
    rd_item.last_in_packet = rd_side_r.last;
    rd_item.peak_offset    = rd_side_r.offset;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_ptr[RING_AW-1:0]] <= wr_data;
    end
    if (issue) begin
      rd_data_r      <= ring_mem[rd_addr[RING_AW-1:0]];
      rd_side_r.last <= head_cmd.last && final_rd;
      rd_side_r.offset <= head_cmd.offset;
    end
    if (rd_vld_r) begin
      obuf[otail_r] <= rd_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      free_r   <= '0;
      rd_vld_r <= 1'b0;
      ohead_r  <= 1'b0;
      otail_r  <= 1'b0;
      occ_r    <= 2'd0;
    end else begin
      cnt_r    <= cnt_nxt;
      free_r   <= free_nxt;
      rd_vld_r <= issue;
      ohead_r  <= ohead_r ^ out_pop;
      otail_r  <= otail_r ^ rd_vld_r;
      occ_r    <= occ_nxt;
    end
  end

endmodule

/* design/threshold_peak_packet_extractor.sv */
// Path: an accepted sample goes into the ring and, in pass-through or when it closes a detection
//   window, a burst goes into the queue; the back end reads into a read register, then the output buffer.
// Throughput: one sample per cycle in and, while out_ready holds, out; in_ready falls when the ring
//   (2*MAX_PACKET_LEN deep) or the 4-entry burst queue fills, e.g. in pass-through behind a long window burst.
// Reset: rst_n synchronous, active low; clears control state and config to defaults,
//   ring contents are left as they are.
module threshold_peak_packet_extractor #(
  parameter int MAX_PACKET_LEN = tppe_pkg::MAX_PACKET_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tppe_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tppe_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tppe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tppe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tppe_pkg::*;

  localparam int PTR_W = $clog2(MAX_PACKET_LEN) + 2;

  cfg_t             cfg_r;
  logic             wr_en;
  logic [PTR_W-1:0] wr_ptr;
  logic [IQ_W-1:0]  wr_data;
  logic             cmd_push;
  cmd_t             cmd;
  logic [PTR_W-1:0] cmd_start;
  cmd_t             head_cmd;
  logic [PTR_W-1:0] head_start;
  logic             head_valid;
  logic             cmdq_full;
  logic             cmd_pop;
  logic [PTR_W-1:0] free_ptr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.energy_threshold <= THRESHOLD_RST;
      cfg_r.packet_len       <= PACKET_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENERGY_THRESHOLD: cfg_r.energy_threshold <= cfg_wdata;
        REG_PACKET_LEN:       cfg_r.packet_len       <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  tppe_front #(
    .MAX_PACKET_LEN(MAX_PACKET_LEN),
    .PTR_W(PTR_W)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .free_ptr(free_ptr),
    .cmdq_full(cmdq_full),
    .wr_en(wr_en),
    .wr_ptr(wr_ptr),
    .wr_data(wr_data),
    .cmd_push(cmd_push),
    .cmd(cmd),
    .cmd_start(cmd_start)
  );

  tppe_cmd_fifo #(
    .PTR_W(PTR_W)
  ) u_cmdq (
    .clk(clk),
    .rst_n(rst_n),
    .push(cmd_push),
    .push_cmd(cmd),
    .push_start(cmd_start),
    .pop(cmd_pop),
    .head_cmd(head_cmd),
    .head_start(head_start),
    .head_valid(head_valid),
    .full(cmdq_full)
  );

  tppe_back #(
    .MAX_PACKET_LEN(MAX_PACKET_LEN),
    .PTR_W(PTR_W)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .wr_en(wr_en),
    .wr_ptr(wr_ptr),
    .wr_data(wr_data),
    .head_valid(head_valid),
    .head_cmd(head_cmd),
    .head_start(head_start),
    .pop(cmd_pop),
    .free_ptr(free_ptr),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule
